[src/i2cms_pkg.sv]
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, command codes, phase codes and segment functions shared by the
// i2c master byte sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // command codes
  localparam logic [2:0] CMD_NONE     = 3'd0;
  localparam logic [2:0] CMD_START    = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_SEND     = 3'd3;
  localparam logic [2:0] CMD_RECEIVE  = 3'd4;
  localparam logic [2:0] CMD_WAIT_ACK = 3'd5;

  // phase codes
  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_ST_A    = 5'd1;
  localparam logic [4:0] PH_ST_B    = 5'd2;
  localparam logic [4:0] PH_ST_FIN  = 5'd3;
  localparam logic [4:0] PH_SP_A    = 5'd4;
  localparam logic [4:0] PH_SP_B    = 5'd5;
  localparam logic [4:0] PH_SP_FIN  = 5'd6;
  localparam logic [4:0] PH_TX_SET  = 5'd7;
  localparam logic [4:0] PH_TX_HIGH = 5'd8;
  localparam logic [4:0] PH_TX_LOW  = 5'd9;
  localparam logic [4:0] PH_TX_FIN  = 5'd10;
  localparam logic [4:0] PH_RX_LOW  = 5'd11;
  localparam logic [4:0] PH_RX_HIGH = 5'd12;
  localparam logic [4:0] PH_RA_LOW  = 5'd13;
  localparam logic [4:0] PH_RA_HIGH = 5'd14;
  localparam logic [4:0] PH_RX_FIN  = 5'd15;
  localparam logic [4:0] PH_WA_REL  = 5'd16;
  localparam logic [4:0] PH_WA_HIGH = 5'd17;
  localparam logic [4:0] PH_WA_POLL = 5'd18;

  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } result_t;

  typedef struct packed {
    logic [4:0] phase;
    logic [2:0] tick_count;
    logic [3:0] bit_index;
    logic [7:0] shift_reg;
    logic [7:0] wait_count;
    logic       scl_reg;
    logic       sda_reg;
    logic       sda_dir;
    logic       ack_choice;
    logic [7:0] rx_reg;
    logic       fail_flag;
  } seq_state_t;

  // line changes on the first tick of a segment; a finishing segment returns to idle
  function automatic seq_state_t enter_seg(seq_state_t st, logic [4:0] p, logic sda_in);
    seq_state_t n;
    logic [2:0] hold;
    logic       fin;
    n    = st;
    hold = 3'd0;
    fin  = 1'b0;
    case (p)
      PH_ST_A: begin
        n.sda_dir = 1'b1; n.sda_reg = 1'b1; n.scl_reg = 1'b1; hold = 3'd3;
      end
      PH_ST_B: begin
        n.sda_reg = 1'b0; hold = 3'd3;
      end
      PH_ST_FIN: begin
        n.scl_reg = 1'b0; fin = 1'b1;
      end
      PH_SP_A: begin
        n.sda_dir = 1'b1; n.scl_reg = 1'b0; n.sda_reg = 1'b0; hold = 3'd3;
      end
      PH_SP_B: begin
        n.scl_reg = 1'b1; n.sda_reg = 1'b1; hold = 3'd3;
      end
      PH_SP_FIN: fin = 1'b1;
      PH_TX_SET: begin
        n.sda_dir   = 1'b1;
        n.scl_reg   = 1'b0;
        n.sda_reg   = st.shift_reg[7];
        n.shift_reg = {st.shift_reg[6:0], 1'b0};
        n.bit_index = st.bit_index + 4'd1;
        hold        = 3'd1;
      end
      PH_TX_HIGH: begin
        n.scl_reg = 1'b1; hold = 3'd1;
      end
      PH_TX_LOW: begin
        n.scl_reg = 1'b0; hold = 3'd1;
      end
      PH_TX_FIN: fin = 1'b1;
      PH_RX_LOW: begin
        n.sda_dir = 1'b0; n.scl_reg = 1'b0; hold = 3'd1;
      end
      PH_RX_HIGH: begin
        n.scl_reg   = 1'b1;
        n.shift_reg = {st.shift_reg[6:0], sda_in};
        n.bit_index = st.bit_index + 4'd1;
      end
      PH_RA_LOW: begin
        n.scl_reg = 1'b0;
        n.sda_dir = 1'b1;
        n.sda_reg = ~st.ack_choice;
        hold      = 3'd1;
      end
      PH_RA_HIGH: begin
        n.scl_reg = 1'b1; hold = 3'd1;
      end
      PH_RX_FIN: begin
        n.scl_reg = 1'b0; n.rx_reg = st.shift_reg; fin = 1'b1;
      end
      PH_WA_REL: begin
        n.sda_dir    = 1'b0;
        n.sda_reg    = 1'b1;
        n.fail_flag  = 1'b0;
        n.wait_count = 8'd0;
      end
      PH_WA_HIGH: n.scl_reg = 1'b1;
      PH_WA_POLL: hold = 3'd0;
      default:    fin = 1'b1;
    endcase
    if (fin) begin
      n.phase      = PH_IDLE;
      n.tick_count = 3'd0;
    end else begin
      n.phase      = p;
      n.tick_count = hold;
    end
    return n;
  endfunction

  // segment that follows a finished one
  function automatic logic [4:0] next_seg(logic [4:0] p, logic [3:0] bit_index);
    logic [4:0] r;
    r = PH_IDLE;
    case (p)
      PH_ST_A:    r = PH_ST_B;
      PH_ST_B:    r = PH_ST_FIN;
      PH_SP_A:    r = PH_SP_B;
      PH_SP_B:    r = PH_SP_FIN;
      PH_TX_SET:  r = PH_TX_HIGH;
      PH_TX_HIGH: r = PH_TX_LOW;
      PH_TX_LOW:  r = (bit_index >= BITS_PER_BYTE) ? PH_TX_FIN : PH_TX_SET;
      PH_RX_LOW:  r = PH_RX_HIGH;
      PH_RX_HIGH: r = (bit_index >= BITS_PER_BYTE) ? PH_RA_LOW : PH_RX_LOW;
      PH_RA_LOW:  r = PH_RA_HIGH;
      PH_RA_HIGH: r = PH_RX_FIN;
      PH_WA_REL:  r = PH_WA_HIGH;
      PH_WA_HIGH: r = PH_WA_POLL;
      default:    r = PH_IDLE;
    endcase
    return r;
  endfunction

endpackage

[src/i2cms_if.sv]
// ----------------------------------------------------------------------------
// i2cms_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface i2cms_tick_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, command, tx_byte, send_ack, sda_in, input ready);
  modport sink (input valid, command, tx_byte, send_ack, sda_in, output ready);
endinterface

interface i2cms_result_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_drive;
  logic       sda_level;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                  rx_byte, ack_failed, input ready);
  modport sink (input valid, scl_level, sda_drive, sda_level, busy_res, done_res,
                rx_byte, ack_failed, output ready);
endinterface

[src/i2cms_step.sv]
// ----------------------------------------------------------------------------
// i2cms_step
// Input register plus sequencer state; works out one tick per transfer.
// ----------------------------------------------------------------------------
module i2cms_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           ack_timeout,
  input  logic                 in_valid,
  input  i2cms_pkg::item_t     in_item,
  output logic                 in_ready,
  output logic                 res_valid,
  output i2cms_pkg::result_t   res,
  input  logic                 res_ready
);

  logic                    item_valid;
  i2cms_pkg::item_t        item;
  i2cms_pkg::seq_state_t   state;
  i2cms_pkg::seq_state_t   state_next;
  logic                    done_next;
  logic                    advance;

  assign advance   = item_valid && res_ready;
  assign in_ready  = !item_valid || res_ready;
  assign res_valid = item_valid;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

  // one tick of the sequencer
  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    if (state.phase == i2cms_pkg::PH_IDLE) begin
      case (item.command)
        i2cms_pkg::CMD_START: begin
          state_next = i2cms_pkg::enter_seg(state, i2cms_pkg::PH_ST_A, item.sda_in);
        end
        i2cms_pkg::CMD_STOP: begin
          state_next = i2cms_pkg::enter_seg(state, i2cms_pkg::PH_SP_A, item.sda_in);
        end
        i2cms_pkg::CMD_SEND: begin
          state_next.shift_reg = item.tx_byte;
          state_next.bit_index = 4'd0;
          state_next = i2cms_pkg::enter_seg(state_next, i2cms_pkg::PH_TX_SET, item.sda_in);
        end
        i2cms_pkg::CMD_RECEIVE: begin
          state_next.ack_choice = item.send_ack;
          state_next.bit_index  = 4'd0;
          state_next.shift_reg  = 8'd0;
          state_next = i2cms_pkg::enter_seg(state_next, i2cms_pkg::PH_RX_LOW, item.sda_in);
        end
        i2cms_pkg::CMD_WAIT_ACK: begin
          state_next = i2cms_pkg::enter_seg(state, i2cms_pkg::PH_WA_REL, item.sda_in);
        end
        default: state_next = state;
      endcase
    end else if (state.tick_count != 3'd0) begin
      state_next.tick_count = state.tick_count - 3'd1;
    end else if (state.phase == i2cms_pkg::PH_WA_POLL) begin
      if (!item.sda_in) begin
        state_next.scl_reg = 1'b0;
        state_next.phase   = i2cms_pkg::PH_IDLE;
        done_next          = 1'b1;
      end else if (state.wait_count >= ack_timeout) begin
        state_next.fail_flag = 1'b1;
        state_next = i2cms_pkg::enter_seg(state_next, i2cms_pkg::PH_SP_A, item.sda_in);
      end else begin
        state_next.wait_count = state.wait_count + 8'd1;
      end
    end else begin
      state_next = i2cms_pkg::enter_seg(state,
                     i2cms_pkg::next_seg(state.phase, state.bit_index), item.sda_in);
      done_next  = (state_next.phase == i2cms_pkg::PH_IDLE);
    end
  end

  // result fields for this tick
  always_comb begin
    res.scl_level  = state_next.scl_reg;
    res.sda_drive  = state_next.sda_dir;
    res.sda_level  = state_next.sda_reg;
    res.busy_res   = (state_next.phase != i2cms_pkg::PH_IDLE);
    res.done_res   = done_next;
    res.rx_byte    = state_next.rx_reg;
    res.ack_failed = state_next.fail_flag;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= i2cms_pkg::PH_IDLE;
      state.tick_count <= 3'd0;
      state.bit_index  <= 4'd0;
      state.shift_reg  <= 8'd0;
      state.wait_count <= 8'd0;
      state.scl_reg    <= 1'b1;
      state.sda_reg    <= 1'b1;
      state.sda_dir    <= 1'b0;
      state.ack_choice <= 1'b0;
      state.rx_reg     <= 8'd0;
      state.fail_flag  <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // checks
  a_idle_no_count: assert property (@(posedge clk) disable iff (rst)
    state.phase == i2cms_pkg::PH_IDLE |-> state.tick_count == 3'd0)
    else $error("idle phase with a pending tick count");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.done_res |-> !res.busy_res)
    else $error("done pulse while still busy");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state moved without a transfer");

endmodule

[src/i2cms_out_buf.sv]
// ----------------------------------------------------------------------------
// i2cms_out_buf
// Two-entry result queue between the sequencer and the result channel.
// ----------------------------------------------------------------------------
module i2cms_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  i2cms_pkg::result_t  push_data,
  output logic                push_ready,
  output logic                pop_valid,
  output i2cms_pkg::result_t  pop_data,
  input  logic                pop_ready
);

  i2cms_pkg::result_t  entry [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;
  logic                pop;

  assign pop_valid  = (count != 2'd0);
  assign pop        = pop_valid && pop_ready;
  assign push_ready = (count != 2'd2) || pop_ready;
  assign push       = push_valid && push_ready;
  assign pop_data   = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue overflow");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill level");

endmodule

[src/i2c_master_byte_sequencer_core.sv]
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_core
// I2C master that drives SCL and SDA one tick per accepted item.
// ----------------------------------------------------------------------------
// path: a tick is held in the input register and its result then in the result
//   queue, as earlier ticks permit
// throughput: one tick per cycle while the result channel keeps taking results
// reset: synchronous rst empties both stages, idles the bus (SCL and SDA
//   high, SDA released) and loads ack_timeout with 250
module i2c_master_byte_sequencer_core (
  input  logic                  clk,
  input  logic                  rst,
  i2cms_tick_if.sink            tick,
  i2cms_result_if.source        result,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata
);

  logic [7:0]          ack_timeout;
  i2cms_pkg::item_t    item;
  logic                step_valid;
  logic                step_ready;
  i2cms_pkg::result_t  step_res;
  i2cms_pkg::result_t  out_res;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_timeout <= i2cms_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      ack_timeout <= cfg_wdata;
    end
  end

  // tick payload
  always_comb begin
    item.command  = tick.command;
    item.tx_byte  = tick.tx_byte;
    item.send_ack = tick.send_ack;
    item.sda_in   = tick.sda_in;
  end

  i2cms_step u_step (
    .clk         (clk),
    .rst         (rst),
    .ack_timeout (ack_timeout),
    .in_valid    (tick.valid),
    .in_item     (item),
    .in_ready    (tick.ready),
    .res_valid   (step_valid),
    .res         (step_res),
    .res_ready   (step_ready)
  );

  i2cms_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (step_valid),
    .push_data  (step_res),
    .push_ready (step_ready),
    .pop_valid  (result.valid),
    .pop_data   (out_res),
    .pop_ready  (result.ready)
  );

  // result payload
  assign result.scl_level  = out_res.scl_level;
  assign result.sda_drive  = out_res.sda_drive;
  assign result.sda_level  = out_res.sda_level;
  assign result.busy_res   = out_res.busy_res;
  assign result.done_res   = out_res.done_res;
  assign result.rx_byte    = out_res.rx_byte;
  assign result.ack_failed = out_res.ack_failed;

endmodule
